@@ rtl/rwq_pkg.sv @@
// Shared constants for the R-tree window query block.
package rwq_pkg;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;
  localparam int unsigned MAX_LEVELS_DEF  = 16;
  localparam int unsigned STACK_DEPTH_DEF = 512;
  localparam int unsigned COORD_BITS_DEF  = 32;
  localparam int unsigned MAX_HITS_DEF    = 64;

  localparam int unsigned IN_COORD_W = 32;
  localparam int unsigned LINK_W     = 12;
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned NODE_W     = 13;
  localparam int unsigned POS_W      = 14;
  localparam int unsigned NSIZE_W    = 7;
  localparam int unsigned LCNT_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 13;

  localparam logic [1:0] OP_WR_ENTRY = 2'd0;
  localparam logic [1:0] OP_WR_LEVEL = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CUT      = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd3;
endpackage

@@ rtl/rwq_ram.sv @@
// Generic simple dual-port RAM with registered read.
module rwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/rtree_window_query_core.sv @@
// Top level: R-tree window query sequencer with box, link and stack memories.
//
// Usage: items arrive on the in_ channel (valid/stall). Opcode 0 writes one
// entry (box and link), opcode 1 writes one level end, opcode 2 runs a
// window query. Writes give no result. A query streams
// its hits on the out_ channel in walk order; the final result carries
// last=1 and the status, and a query without hits gives one empty result.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must do so only while the block is idle; the block does not enforce it.
// Each child box is read from the box memory, which has a registered read, and
// each visited node first runs a binary search over the level ends.
// in_stall is high while a query runs.
// When the receiver stalls, the held result stays on the out_ ports and the
// walk waits at the next hit. Reset clears the control state and sets the
// configuration registers to defaults; the memories hold nothing until written.
module rtree_window_query_core #(
  parameter int unsigned MAX_ENTRIES = rwq_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MAX_LEVELS  = rwq_pkg::MAX_LEVELS_DEF,
  parameter int unsigned STACK_DEPTH = rwq_pkg::STACK_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = rwq_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_HITS    = rwq_pkg::MAX_HITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rwq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rwq_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic [rwq_pkg::SLOT_W-1:0]           in_slot,
  input  logic signed [rwq_pkg::IN_COORD_W-1:0] in_min_x,
  input  logic signed [rwq_pkg::IN_COORD_W-1:0] in_min_y,
  input  logic signed [rwq_pkg::IN_COORD_W-1:0] in_max_x,
  input  logic signed [rwq_pkg::IN_COORD_W-1:0] in_max_y,
  input  logic [rwq_pkg::LINK_W-1:0]           in_link,
  input  logic [rwq_pkg::NODE_W-1:0]           in_level_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rwq_pkg::LINK_W-1:0]           out_hit_index,
  output logic                                 out_has_hit,
  output logic                                 out_last,
  output logic [1:0]                           out_status
);
  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned LW  = $clog2(MAX_LEVELS);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned HW  = $clog2(MAX_HITS + 1);
  localparam int unsigned BW  = 4 * COORD_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NODE = 3'd1;
  localparam logic [2:0] S_LB   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_POPW = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // configuration
  logic [rwq_pkg::NSIZE_W-1:0] node_size_r;
  logic [rwq_pkg::NODE_W-1:0]  item_count_r, entry_count_r;
  logic [rwq_pkg::LCNT_W-1:0]  level_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_size_r   <= rwq_pkg::NSIZE_W'(16);
      item_count_r  <= '0;
      entry_count_r <= '0;
      level_count_r <= rwq_pkg::LCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rwq_pkg::CFG_NODE_SIZE:   node_size_r   <= cfg_wdata[rwq_pkg::NSIZE_W-1:0];
        rwq_pkg::CFG_ITEM_COUNT:  item_count_r  <= cfg_wdata;
        rwq_pkg::CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata;
        rwq_pkg::CFG_LEVEL_COUNT: level_count_r <= cfg_wdata[rwq_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]                   state_r, state_nxt;
  logic [rwq_pkg::NODE_W-1:0]   node_r, node_nxt;
  logic [rwq_pkg::POS_W-1:0]    pos_r, pos_nxt, end_r, end_nxt;
  logic                         leaf_r, leaf_nxt;
  logic [LW-1:0]                lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SCW-1:0]               sp_r, sp_nxt;
  logic [VW-1:0]                visits_r, visits_nxt;
  logic [HW-1:0]                count_r, count_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic                         hold_valid_r, hold_valid_nxt;
  logic [rwq_pkg::LINK_W-1:0]   hold_idx_r, hold_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rwq_pkg::LINK_W-1:0]   out_idx_r, out_idx_nxt;
  logic                         out_has_r, out_has_nxt, out_last_r, out_last_nxt;
  logic [1:0]                   out_st_r, out_st_nxt;
  logic signed [COORD_BITS-1:0] qx0_r, qy0_r, qx1_r, qy1_r;
  logic [rwq_pkg::NODE_W-1:0]   lend_r [MAX_LEVELS];

  logic in_acc, out_free;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // entry, level-end and query-window write path
  logic [31:0] slot_ext;
  logic        wr_entry;
  assign slot_ext = 32'(in_slot);
  assign wr_entry = in_acc && (in_opcode == rwq_pkg::OP_WR_ENTRY) && (slot_ext < MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == rwq_pkg::OP_WR_LEVEL) && (slot_ext < MAX_LEVELS)) begin
      lend_r[slot_ext[LW-1:0]] <= in_level_end;
    end
    if (in_acc && (in_opcode == rwq_pkg::OP_QUERY)) begin
      qx0_r <= in_min_x[COORD_BITS-1:0];
      qy0_r <= in_min_y[COORD_BITS-1:0];
      qx1_r <= in_max_x[COORD_BITS-1:0];
      qy1_r <= in_max_y[COORD_BITS-1:0];
    end
  end

  // memories
  logic [31:0]               pos_ext;
  logic                      rd_en;
  logic [BW-1:0]             box_rdata;
  logic [rwq_pkg::LINK_W-1:0] link_rdata, stk_rdata;
  logic                      push_en, pop_en;
  logic [31:0]               sp_ext, sp_m1_ext;

  assign pos_ext   = 32'(pos_r);
  assign sp_ext    = 32'(sp_r);
  assign sp_m1_ext = 32'(sp_r) - 32'd1;

  rwq_ram #(.WIDTH(BW), .DEPTH(MAX_ENTRIES)) u_box (
    .clk, .we(wr_entry), .waddr(slot_ext[AW-1:0]),
    .wdata({in_min_x[COORD_BITS-1:0], in_min_y[COORD_BITS-1:0],
            in_max_x[COORD_BITS-1:0], in_max_y[COORD_BITS-1:0]}),
    .re(rd_en), .raddr(pos_ext[AW-1:0]), .rdata(box_rdata)
  );

  rwq_ram #(.WIDTH(rwq_pkg::LINK_W), .DEPTH(MAX_ENTRIES)) u_link (
    .clk, .we(wr_entry), .waddr(slot_ext[AW-1:0]), .wdata(in_link),
    .re(rd_en), .raddr(pos_ext[AW-1:0]), .rdata(link_rdata)
  );

  rwq_ram #(.WIDTH(rwq_pkg::LINK_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(push_en), .waddr(sp_ext[SAW-1:0]), .wdata(link_rdata),
    .re(pop_en), .raddr(sp_m1_ext[SAW-1:0]), .rdata(stk_rdata)
  );

  // overlap test
  logic signed [COORD_BITS-1:0] bx0, by0, bx1, by1;
  logic                         overlap;
  assign {bx0, by0, bx1, by1} = box_rdata;
  assign overlap = !(qx1_r < bx0) && !(qy1_r < by0) && !(qx0_r > bx1) && !(qy0_r > by1);

  // level bound search
  logic [LW-1:0]              lvl_last;
  logic [LW:0]                mid_sum;
  logic [LW-1:0]              mid;
  logic [rwq_pkg::POS_W-1:0]  node_plus, bound_ext;
  always_comb begin
    if (level_count_r == '0) lvl_last = '0;
    else if (32'(level_count_r) > MAX_LEVELS) lvl_last = LW'(MAX_LEVELS - 1);
    else lvl_last = LW'(level_count_r - rwq_pkg::LCNT_W'(1));
  end
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[LW:1];
  assign node_plus = rwq_pkg::POS_W'(node_r) + rwq_pkg::POS_W'(node_size_r);
  assign bound_ext = rwq_pkg::POS_W'(lend_r[lo_r]);

  always_comb begin
    state_nxt      = state_r;
    node_nxt       = node_r;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    leaf_nxt       = leaf_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    sp_nxt         = sp_r;
    visits_nxt     = visits_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    hold_valid_nxt = hold_valid_r;
    hold_idx_nxt   = hold_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_idx_nxt    = out_idx_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    out_st_nxt     = out_st_r;
    rd_en          = 1'b0;
    push_en        = 1'b0;
    pop_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_opcode == rwq_pkg::OP_QUERY)) begin
          sp_nxt         = '0;
          visits_nxt     = '0;
          count_nxt      = '0;
          status_nxt     = rwq_pkg::ST_OK;
          hold_valid_nxt = 1'b0;
          node_nxt       = entry_count_r - rwq_pkg::NODE_W'(1);
          state_nxt      = (entry_count_r == '0) ? S_FIN : S_NODE;
        end
      end
      S_NODE: begin
        if (32'(visits_r) >= MAX_ENTRIES) begin
          status_nxt = rwq_pkg::ST_OVERFLOW;
          state_nxt  = S_FIN;
        end else begin
          visits_nxt = visits_r + VW'(1);
          lo_nxt     = '0;
          hi_nxt     = lvl_last;
          leaf_nxt   = node_r < item_count_r;
          pos_nxt    = rwq_pkg::POS_W'(node_r);
          state_nxt  = S_LB;
        end
      end
      S_LB: begin
        if (lo_r < hi_r) begin
          if (lend_r[mid] > node_r) hi_nxt = mid;
          else lo_nxt = mid + LW'(1);
        end else begin
          end_nxt   = (bound_ext < node_plus) ? bound_ext : node_plus;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if ((pos_r < end_r) && (pos_ext < MAX_ENTRIES)) begin
          rd_en     = 1'b1;
          state_nxt = S_CMP;
        end else if (sp_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          pop_en    = 1'b1;
          sp_nxt    = sp_r - SCW'(1);
          state_nxt = S_POPW;
        end
      end
      S_CMP: begin
        if (!overlap) begin
          pos_nxt   = pos_r + rwq_pkg::POS_W'(1);
          state_nxt = S_RD;
        end else if (leaf_r) begin
          if (32'(count_r) < MAX_HITS) begin
            if (!hold_valid_r || out_free) begin
              if (hold_valid_r) begin
                out_valid_nxt = 1'b1;
                out_idx_nxt   = hold_idx_r;
                out_has_nxt   = 1'b1;
                out_last_nxt  = 1'b0;
                out_st_nxt    = rwq_pkg::ST_OK;
              end
              hold_valid_nxt = 1'b1;
              hold_idx_nxt   = link_rdata;
              count_nxt      = count_r + HW'(1);
              pos_nxt        = pos_r + rwq_pkg::POS_W'(1);
              state_nxt      = S_RD;
            end
          end else begin
            if (status_r == rwq_pkg::ST_OK) status_nxt = rwq_pkg::ST_CUT;
            pos_nxt   = pos_r + rwq_pkg::POS_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          if (sp_ext < STACK_DEPTH) begin
            push_en = 1'b1;
            sp_nxt  = sp_r + SCW'(1);
          end else begin
            status_nxt = rwq_pkg::ST_OVERFLOW;
          end
          pos_nxt   = pos_r + rwq_pkg::POS_W'(1);
          state_nxt = S_RD;
        end
      end
      S_POPW: begin
        node_nxt  = rwq_pkg::NODE_W'(stk_rdata);
        state_nxt = S_NODE;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = hold_valid_r ? hold_idx_r : '0;
          out_has_nxt    = hold_valid_r;
          out_last_nxt   = 1'b1;
          out_st_nxt     = status_r;
          hold_valid_nxt = 1'b0;
          sp_nxt         = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      visits_r     <= '0;
      count_r      <= '0;
      status_r     <= rwq_pkg::ST_OK;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      visits_r     <= visits_nxt;
      count_r      <= count_nxt;
      status_r     <= status_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    pos_r      <= pos_nxt;
    end_r      <= end_nxt;
    leaf_r     <= leaf_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    hold_idx_r <= hold_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit_index = out_idx_r;
  assign out_has_hit   = out_has_r;
  assign out_last      = out_last_r;
  assign out_status    = out_st_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= STACK_DEPTH) else $error("stack pointer beyond depth");
  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_HITS) else $error("hit count beyond limit");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> out_last_r) else $error("empty result not last");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_st_r == rwq_pkg::ST_OK))
    else $error("status on non-final result");
endmodule
